>>> rtl/core/ofv_pkg.sv
// ----------------------------------------------------------------------------
// ofv_pkg
// Shared types, constants and helpers for the optical flow velocity core.
// ----------------------------------------------------------------------------
package ofv_pkg;

   localparam int FILTER_LEN    = 10;
   localparam int PAYLOAD_BYTES = 12;
   localparam int IDX_W   = (FILTER_LEN > 1) ? $clog2(FILTER_LEN) : 1;
   localparam int BCNT_W  = $clog2(PAYLOAD_BYTES);
   localparam int SPEED_W = 40;
   localparam int DISP_W  = 48;
   localparam int SUM_W   = SPEED_W + IDX_W;
   localparam int GAIN_W  = 20;
   localparam int CONF_W  = 17;

   localparam logic [7:0]        HDR_FIRST  = 8'hAA;
   localparam logic [7:0]        HDR_SECOND = 8'hAE;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 20'd74699;
   localparam int                CONF_MAX   = 100000;

   localparam int PLAIN_DIV = 300000;
   localparam int GYRO_DIV  = 15360;
   localparam int DISP_DIV  = 1000;

   // radix-256 divider: each quotient digit from a reciprocal multiply,
   // formed as the digit first, then the remainder
   localparam int DIV_DIGITS = 8;
   localparam int DIV_ITERS  = 2 * DIV_DIGITS;
   localparam int IT_W       = $clog2(DIV_ITERS);
   localparam int DVS_W      = 19;
   localparam int PART_W     = DVS_W + 8;

   // shift 9 + 2*clog2(d) keeps floor(p*M >> s) exact for p < 256*d
   localparam int PLAIN_SH = 9 + 2 * $clog2(PLAIN_DIV);
   localparam int GYRO_SH  = 9 + 2 * $clog2(GYRO_DIV);
   localparam int FILT_SH  = 9 + 2 * $clog2(FILTER_LEN);
   localparam int DISP_SH  = 9 + 2 * $clog2(DISP_DIV);

   localparam longint PLAIN_RCP =
      ((longint'(1) << PLAIN_SH) + longint'(PLAIN_DIV) - 1) / longint'(PLAIN_DIV);
   localparam longint GYRO_RCP =
      ((longint'(1) << GYRO_SH) + longint'(GYRO_DIV) - 1) / longint'(GYRO_DIV);
   localparam longint FILT_RCP =
      ((longint'(1) << FILT_SH) + longint'(FILTER_LEN) - 1) / longint'(FILTER_LEN);
   localparam longint DISP_RCP =
      ((longint'(1) << DISP_SH) + longint'(DISP_DIV) - 1) / longint'(DISP_DIV);

   localparam int RCP_W  = $clog2(PLAIN_RCP + 1);
   localparam int PROD_W = PART_W + RCP_W;
   localparam int SH_W   = 6;

   localparam logic CSR_ROLL_GAIN  = 1'b0;
   localparam logic CSR_PITCH_GAIN = 1'b1;

   typedef enum logic [2:0] {
      OP_PX, OP_PY, OP_GX, OP_GY, OP_SX, OP_SY, OP_DX, OP_DY
   } op_type;

   typedef struct packed {
      logic              store_byte;
      logic [BCNT_W-1:0] byte_idx;
      logic              capture;
      logic              mul1;
      logic              mul2;
      logic              div_load;
      logic              div_step;
      logic              div_store;
      logic              ring;
      logic              load_out;
      op_type            op;
   } cmd_type;

   typedef struct packed {
      logic             out_free;
      logic [IDX_W-1:0] ring_idx;
   } status_type;

   function automatic logic [DVS_W-1:0] divisor_of(input op_type op);
      case (op)
         OP_PX, OP_PY: divisor_of = DVS_W'(PLAIN_DIV);
         OP_GX, OP_GY: divisor_of = DVS_W'(GYRO_DIV);
         OP_SX, OP_SY: divisor_of = DVS_W'(FILTER_LEN);
         default:      divisor_of = DVS_W'(DISP_DIV);
      endcase
   endfunction

   function automatic logic [DVS_W-1:0] half_of(input op_type op);
      case (op)
         OP_PX, OP_PY: half_of = DVS_W'(PLAIN_DIV / 2);
         OP_GX, OP_GY: half_of = DVS_W'(GYRO_DIV / 2);
         OP_SX, OP_SY: half_of = DVS_W'(FILTER_LEN / 2);
         default:      half_of = DVS_W'(DISP_DIV / 2);
      endcase
   endfunction

   function automatic logic [RCP_W-1:0] recip_of(input op_type op);
      case (op)
         OP_PX, OP_PY: recip_of = RCP_W'(PLAIN_RCP);
         OP_GX, OP_GY: recip_of = RCP_W'(GYRO_RCP);
         OP_SX, OP_SY: recip_of = RCP_W'(FILT_RCP);
         default:      recip_of = RCP_W'(DISP_RCP);
      endcase
   endfunction

   function automatic logic [SH_W-1:0] shift_of(input op_type op);
      case (op)
         OP_PX, OP_PY: shift_of = SH_W'(PLAIN_SH);
         OP_GX, OP_GY: shift_of = SH_W'(GYRO_SH);
         OP_SX, OP_SY: shift_of = SH_W'(FILT_SH);
         default:      shift_of = SH_W'(DISP_SH);
      endcase
   endfunction

   function automatic logic signed [SPEED_W-1:0] sat40(input logic signed [48:0] v);
      if (v > 49'sd549755813887)       sat40 = {1'b0, {(SPEED_W-1){1'b1}}};
      else if (v < -49'sd549755813888) sat40 = {1'b1, {(SPEED_W-1){1'b0}}};
      else                             sat40 = v[SPEED_W-1:0];
   endfunction

   function automatic logic signed [DISP_W-1:0] sat48(input logic signed [48:0] v);
      if (v[48] != v[47]) sat48 = v[48] ? {1'b1, {(DISP_W-1){1'b0}}}
                                        : {1'b0, {(DISP_W-1){1'b1}}};
      else                sat48 = v[DISP_W-1:0];
   endfunction

endpackage

>>> rtl/core/ofv_div.sv
// ----------------------------------------------------------------------------
// ofv_div
// Constant divider, unsigned 64-bit dividend, radix-256 quotient digits
// by reciprocal multiplication, each digit first, then its remainder.
// ----------------------------------------------------------------------------
module ofv_div import ofv_pkg::*; (
   input  logic             clock,
   input  logic             load,
   input  logic             step,
   input  logic [63:0]      dividend,
   input  logic [DVS_W-1:0] divisor,
   input  logic [RCP_W-1:0] rcp,
   input  logic [SH_W-1:0]  shamt,
   output logic [63:0]      quotient
);

   logic [63:0]       work_ff, work_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff;
   logic [RCP_W-1:0]  rcp_ff;
   logic [SH_W-1:0]   sh_ff;
   logic [7:0]        dig_ff, dig_in;
   logic              phase_ff;
   logic [PART_W-1:0] part;
   logic [PROD_W-1:0] prod;

   // partial remainder stays below 256 * divisor, so the digit fits a byte
   always_comb begin
      part    = {rem_ff, work_ff[63:56]};
      prod    = PROD_W'(part) * PROD_W'(rcp_ff);
      dig_in  = 8'(prod >> sh_ff);
      rem_in  = DVS_W'(part - PART_W'(dig_ff) * PART_W'(dvs_ff));
      work_in = {work_ff[55:0], dig_ff};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         work_ff  <= dividend;
         rem_ff   <= '0;
         dvs_ff   <= divisor;
         rcp_ff   <= rcp;
         sh_ff    <= shamt;
         phase_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= !phase_ff;
         if (!phase_ff) begin
            dig_ff <= dig_in;
         end else begin
            work_ff <= work_in;
            rem_ff  <= rem_in;
         end
      end
   end

   assign quotient = work_ff;

endmodule

>>> rtl/core/ofv_dp.sv
// ----------------------------------------------------------------------------
// ofv_dp
// Datapath: payload store, products, rounding division, filter ring and
// displacement accumulators, result register.
// ----------------------------------------------------------------------------
module ofv_dp import ofv_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic                      csr_write,
   input  logic                      csr_index,
   input  logic [GAIN_W-1:0]         csr_wdata,
   input  logic [7:0]                req_rx_byte,
   input  logic [15:0]               req_height_mm,
   input  logic signed [19:0]        req_gyro_roll_rate,
   input  logic signed [19:0]        req_gyro_pitch_rate,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [SPEED_W-1:0] rsp_speed_x,
   output logic signed [SPEED_W-1:0] rsp_speed_y,
   output logic signed [SPEED_W-1:0] rsp_plain_speed_x,
   output logic signed [SPEED_W-1:0] rsp_plain_speed_y,
   output logic signed [DISP_W-1:0]  rsp_offset_x,
   output logic signed [DISP_W-1:0]  rsp_offset_y,
   output logic [CONF_W-1:0]         rsp_confidence_raw
);

   logic [7:0]               payload_ff [PAYLOAD_BYTES];
   logic [15:0]              h_ff;
   logic signed [19:0]       gr_ff, gp_ff;
   logic [GAIN_W-1:0]        roll_gain_ff, pitch_gain_ff;
   logic signed [49:0]       prod_x_ff, prod_y_ff;
   logic signed [40:0]       gm_x_ff, gm_y_ff;
   logic signed [57:0]       gn_x_ff, gn_y_ff;
   logic signed [47:0]       px_ff, py_ff, gx_ff, gy_ff;
   logic signed [SPEED_W-1:0] ring_x_ff [FILTER_LEN];
   logic signed [SPEED_W-1:0] ring_y_ff [FILTER_LEN];
   logic [IDX_W-1:0]         idx_ff;
   logic signed [SUM_W-1:0]  sum_x_ff, sum_y_ff;
   logic signed [SPEED_W-1:0] sx_ff, sy_ff;
   logic signed [DISP_W-1:0] disp_x_ff, disp_y_ff;
   logic                     neg_ff;
   logic                     rsp_valid_ff;

   logic signed [31:0] word_a, word_b, word_c;
   logic signed [32:0] neg_b;
   logic signed [16:0] h_s;
   logic signed [63:0] num;
   logic [63:0]        dividend;
   logic [63:0]        quotient;
   logic signed [63:0] res;
   logic signed [SPEED_W-1:0] cx, cy;
   logic [CONF_W-1:0]  conf;

   assign word_a = {payload_ff[3],  payload_ff[2],  payload_ff[1],  payload_ff[0]};
   assign word_b = {payload_ff[7],  payload_ff[6],  payload_ff[5],  payload_ff[4]};
   assign word_c = {payload_ff[11], payload_ff[10], payload_ff[9],  payload_ff[8]};
   assign neg_b  = -33'(word_b);
   assign h_s    = $signed({1'b0, h_ff});

   always_comb begin
      case (cmd.op)
         OP_PX:   num = {prod_x_ff[47:0], 16'h0};
         OP_PY:   num = {prod_y_ff[47:0], 16'h0};
         OP_GX:   num = 64'(gn_x_ff);
         OP_GY:   num = 64'(gn_y_ff);
         OP_SX:   num = 64'(sum_x_ff);
         OP_SY:   num = 64'(sum_y_ff);
         OP_DX:   num = 64'(sx_ff);
         default: num = 64'(sy_ff);
      endcase
      // |num| + d/2 in one add: for negatives ~num + 1 + d/2
      dividend = (num[63] ? ~num : num)
               + (num[63] ? 64'(half_of(cmd.op)) + 64'd1 : 64'(half_of(cmd.op)));
   end

   ofv_div u_div (
      .clock    (clock),
      .load     (cmd.div_load),
      .step     (cmd.div_step),
      .dividend (dividend),
      .divisor  (divisor_of(cmd.op)),
      .rcp      (recip_of(cmd.op)),
      .shamt    (shift_of(cmd.op)),
      .quotient (quotient)
   );

   assign res = neg_ff ? -$signed(quotient) : $signed(quotient);
   assign cx  = sat40(49'(px_ff) + 49'(gx_ff));
   assign cy  = sat40(49'(py_ff) + 49'(gy_ff));

   always_comb begin
      if (word_c[31])                 conf = '0;
      else if (word_c > 32'sd100000)  conf = CONF_W'(CONF_MAX);
      else                            conf = word_c[CONF_W-1:0];
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      if (cmd.store_byte) payload_ff[cmd.byte_idx] <= req_rx_byte;
      if (cmd.capture) begin
         h_ff  <= req_height_mm;
         gr_ff <= req_gyro_roll_rate;
         gp_ff <= req_gyro_pitch_rate;
      end
      if (cmd.mul1) begin
         prod_x_ff <= neg_b * h_s;
         prod_y_ff <= word_a * h_s;
         gm_x_ff   <= $signed({1'b0, roll_gain_ff}) * gr_ff;
         gm_y_ff   <= $signed({1'b0, pitch_gain_ff}) * gp_ff;
      end
      if (cmd.mul2) begin
         gn_x_ff <= gm_x_ff * h_s;
         gn_y_ff <= gm_y_ff * h_s;
      end
      if (cmd.div_load) neg_ff <= num[63];
      if (cmd.div_store) begin
         case (cmd.op)
            OP_PX:   px_ff <= res[47:0];
            OP_PY:   py_ff <= res[47:0];
            OP_GX:   gx_ff <= res[47:0];
            OP_GY:   gy_ff <= res[47:0];
            OP_SX:   sx_ff <= res[SPEED_W-1:0];
            OP_SY:   sy_ff <= res[SPEED_W-1:0];
            default: ;
         endcase
      end
      if (cmd.load_out) begin
         rsp_speed_x        <= sx_ff;
         rsp_speed_y        <= sy_ff;
         rsp_plain_speed_x  <= sat40(49'(px_ff));
         rsp_plain_speed_y  <= sat40(49'(py_ff));
         rsp_offset_x       <= disp_x_ff;
         rsp_offset_y       <= disp_y_ff;
         rsp_confidence_raw <= conf;
      end
   end

   // filter, accumulators, gains and result handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FILTER_LEN; i++) begin
            ring_x_ff[i] <= '0;
            ring_y_ff[i] <= '0;
         end
         idx_ff        <= '0;
         sum_x_ff      <= '0;
         sum_y_ff      <= '0;
         disp_x_ff     <= '0;
         disp_y_ff     <= '0;
         roll_gain_ff  <= GAIN_RESET;
         pitch_gain_ff <= GAIN_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_ROLL_GAIN:  roll_gain_ff  <= csr_wdata;
               CSR_PITCH_GAIN: pitch_gain_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.ring) begin
            sum_x_ff <= sum_x_ff + SUM_W'(cx) - SUM_W'(ring_x_ff[idx_ff]);
            sum_y_ff <= sum_y_ff + SUM_W'(cy) - SUM_W'(ring_y_ff[idx_ff]);
            ring_x_ff[idx_ff] <= cx;
            ring_y_ff[idx_ff] <= cy;
            idx_ff <= (idx_ff == IDX_W'(FILTER_LEN - 1)) ? '0 : idx_ff + IDX_W'(1);
         end
         if (cmd.div_store && cmd.op == OP_DX)
            disp_x_ff <= sat48(49'(disp_x_ff) + 49'(res));
         if (cmd.div_store && cmd.op == OP_DY)
            disp_y_ff <= sat48(49'(disp_y_ff) + 49'(res));
         if (cmd.load_out)      rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)   rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign status.ring_idx = idx_ff;

endmodule

>>> rtl/core/ofv_ctrl.sv
// ----------------------------------------------------------------------------
// ofv_ctrl
// Controller: header hunt, payload count and the per-frame compute sequence.
// ----------------------------------------------------------------------------
module ofv_ctrl import ofv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_rx_byte,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL1, S_MUL2, S_LOAD, S_RUN, S_STORE, S_RING, S_OUT
   } state_type;

   typedef enum logic [1:0] {
      H_FIRST, H_SECOND, H_PAYLOAD
   } hunt_type;

   state_type         state_ff, state_in;
   hunt_type          hunt_ff, hunt_in;
   logic [BCNT_W-1:0] bcnt_ff, bcnt_in;
   op_type            op_ff, op_in;
   logic [IT_W-1:0]   it_ff, it_in;
   logic              accept;

   assign req_stall = state_ff != S_IDLE;
   assign accept    = req_valid && state_ff == S_IDLE;

   always_comb begin
      state_in     = state_ff;
      hunt_in      = hunt_ff;
      bcnt_in      = bcnt_ff;
      op_in        = op_ff;
      it_in        = it_ff;
      cmd          = '0;
      cmd.op       = op_ff;
      cmd.byte_idx = bcnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (hunt_ff)
                  H_FIRST: begin
                     if (req_rx_byte == HDR_FIRST) hunt_in = H_SECOND;
                  end
                  H_SECOND: begin
                     if (req_rx_byte == HDR_SECOND) begin
                        hunt_in = H_PAYLOAD;
                        bcnt_in = '0;
                     end else begin
                        hunt_in = H_FIRST;
                     end
                  end
                  H_PAYLOAD: begin
                     cmd.store_byte = 1'b1;
                     if (bcnt_ff == BCNT_W'(PAYLOAD_BYTES - 1)) begin
                        hunt_in     = H_FIRST;
                        bcnt_in     = '0;
                        cmd.capture = 1'b1;
                        state_in    = S_MUL1;
                     end else begin
                        bcnt_in = bcnt_ff + BCNT_W'(1);
                     end
                  end
                  default: hunt_in = H_FIRST;
               endcase
            end
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            op_in    = OP_PX;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.div_load = 1'b1;
            it_in        = '0;
            state_in     = S_RUN;
         end
         S_RUN: begin
            cmd.div_step = 1'b1;
            if (it_ff == IT_W'(DIV_ITERS - 1)) state_in = S_STORE;
            else                               it_in    = it_ff + IT_W'(1);
         end
         S_STORE: begin
            cmd.div_store = 1'b1;
            if (op_ff == OP_GY) begin
               state_in = S_RING;
            end else if (op_ff == OP_DY) begin
               state_in = S_OUT;
            end else begin
               op_in    = op_type'(op_ff + 3'd1);
               state_in = S_LOAD;
            end
         end
         S_RING: begin
            cmd.ring = 1'b1;
            op_in    = OP_SX;
            state_in = S_LOAD;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hunt_ff  <= H_FIRST;
         bcnt_ff  <= '0;
         op_ff    <= OP_PX;
         it_ff    <= '0;
      end else begin
         state_ff <= state_in;
         hunt_ff  <= hunt_in;
         bcnt_ff  <= bcnt_in;
         op_ff    <= op_in;
         it_ff    <= it_in;
      end
   end

endmodule

>>> rtl/core/optical_flow_frame_velocity_core.sv
// ----------------------------------------------------------------------------
// optical_flow_frame_velocity_core
// Flow sensor frame decoder with height scaling, gyro compensation, moving
// average and displacement integration.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | rx_byte, height_mm, gyro rates
//  rsp     | out       | rsp_valid/stall   | speeds, offsets, confidence
//  csr     | in        | csr_write         | csr_index, csr_wdata (gains)
//
// Bytes that do not end a frame are accepted back to back, every cycle
// while no frame compute runs. The last payload byte starts the compute:
// two multiplies, four rounding divisions (plain, gyro), the filter update,
// four more divisions (average, offset), each a load, eight radix-256 digits
// (digit, then remainder) and a store, then the result load; req_stall is
// high until that load, longer while a result waits behind a stalled rsp.
// Reset (synchronous) clears filter, accumulators and hunt; reloads gains.
// ----------------------------------------------------------------------------
module optical_flow_frame_velocity_core import ofv_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_rx_byte,
   input  logic [15:0]               req_height_mm,
   input  logic signed [19:0]        req_gyro_roll_rate,
   input  logic signed [19:0]        req_gyro_pitch_rate,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [SPEED_W-1:0] rsp_speed_x,
   output logic signed [SPEED_W-1:0] rsp_speed_y,
   output logic signed [SPEED_W-1:0] rsp_plain_speed_x,
   output logic signed [SPEED_W-1:0] rsp_plain_speed_y,
   output logic signed [DISP_W-1:0]  rsp_offset_x,
   output logic signed [DISP_W-1:0]  rsp_offset_y,
   output logic [CONF_W-1:0]         rsp_confidence_raw,
   input  logic                      csr_write,
   input  logic                      csr_index,
   input  logic [GAIN_W-1:0]         csr_wdata
);

   cmd_type    cmd;
   status_type status;

   ofv_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   ofv_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_rx_byte         (req_rx_byte),
      .req_height_mm       (req_height_mm),
      .req_gyro_roll_rate  (req_gyro_roll_rate),
      .req_gyro_pitch_rate (req_gyro_pitch_rate),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_speed_x         (rsp_speed_x),
      .rsp_speed_y         (rsp_speed_y),
      .rsp_plain_speed_x   (rsp_plain_speed_x),
      .rsp_plain_speed_y   (rsp_plain_speed_y),
      .rsp_offset_x        (rsp_offset_x),
      .rsp_offset_y        (rsp_offset_y),
      .rsp_confidence_raw  (rsp_confidence_raw)
   );

   conf_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_confidence_raw <= CONF_W'(CONF_MAX))
      else $error("confidence above clamp");

   valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.load_out))
      else $error("result raised without a load");

   load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("result overwritten while held");

   ring_idx_range: assert property (@(posedge clock) disable iff (reset)
      int'(status.ring_idx) < FILTER_LEN)
      else $error("filter index out of range");

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for optical_flow_frame_velocity_core: streams sensor
// bytes (noise, broken headers and complete frames), tracks the decoder,
// filter and integrator in a local fixed point model, and checks every
// velocity result field by field under three idle/stall mixes.
// ----------------------------------------------------------------------------
module tb;
   import ofv_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 600;

   typedef struct {
      logic [7:0]         rx;
      logic [15:0]        h;
      logic signed [19:0] gr;
      logic signed [19:0] gp;
   } sensor_byte_t;

   typedef struct {
      logic signed [39:0] sx, sy, psx, psy;
      logic signed [47:0] ox, oy;
      logic [16:0]        conf;
   } velocity_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_rx_byte = '0;
   logic [15:0] req_height_mm = '0;
   logic signed [19:0] req_gyro_roll_rate = '0;
   logic signed [19:0] req_gyro_pitch_rate = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SPEED_W-1:0] rsp_speed_x, rsp_speed_y;
   logic signed [SPEED_W-1:0] rsp_plain_speed_x, rsp_plain_speed_y;
   logic signed [DISP_W-1:0] rsp_offset_x, rsp_offset_y;
   logic [CONF_W-1:0] rsp_confidence_raw;
   logic csr_write = 1'b0;
   logic csr_index = CSR_ROLL_GAIN;
   logic [GAIN_W-1:0] csr_wdata = '0;

   optical_flow_frame_velocity_core u_dut (.*);

   always #6 clock = ~clock;

   sensor_byte_t byte_queue[$];
   velocity_t    velocity_queue[$];
   int errors = 0;
   int frames_seen = 0;
   int bytes_sent = 0;
   int send_idle = 0;
   int recv_idle = 0;
   int quiet_cycles = 0;
   logic req_took = 1'b0;

   // local copy of decoder and filter state
   logic [19:0] roll_gain_m, pitch_gain_m;
   int          hunt, byte_no, ring_pos;
   logic [7:0]  payload [PAYLOAD_BYTES];
   longint      ring_x_m [FILTER_LEN];
   longint      ring_y_m [FILTER_LEN];
   longint      acc_x, acc_y, disp_x_m, disp_y_m;

   function automatic longint round_div(longint n, longint d);
      longint mag, q;
      mag = (n < 0) ? -n : n;
      q = (mag + d / 2) / d;
      return (n < 0) ? -q : q;
   endfunction

   function automatic longint clamp(longint v, int w);
      longint lim;
      lim = (longint'(1) <<< (w - 1)) - 1;
      if (v > lim) return lim;
      if (v < -lim - 1) return -lim - 1;
      return v;
   endfunction

   function automatic longint word_of(int base);
      logic [31:0] w;
      w = {payload[base+3], payload[base+2], payload[base+1], payload[base]};
      return longint'($signed(w));
   endfunction

   task automatic track_byte(sensor_byte_t it);
      longint h, a, b, conf, px, py, cx, cy, sx, sy;
      velocity_t v;
      if (hunt == 0 && it.rx == HDR_FIRST) begin
         hunt = 1;
         return;
      end
      if (hunt == 1 && it.rx == HDR_SECOND) begin
         hunt = 2;
         byte_no = 0;
         return;
      end
      if (hunt != 2) begin
         hunt = 0;
         return;
      end
      payload[byte_no] = it.rx;
      byte_no++;
      if (byte_no < PAYLOAD_BYTES) return;
      hunt = 0;
      byte_no = 0;
      h = longint'(it.h);
      a = word_of(0);
      b = word_of(4);
      conf = word_of(8);
      px = round_div(-b * h * 65536, PLAIN_DIV);
      py = round_div(a * h * 65536, PLAIN_DIV);
      cx = clamp(px + round_div(longint'(roll_gain_m) * longint'(it.gr) * h, GYRO_DIV), 40);
      cy = clamp(py + round_div(longint'(pitch_gain_m) * longint'(it.gp) * h, GYRO_DIV), 40);
      acc_x += cx - ring_x_m[ring_pos];
      acc_y += cy - ring_y_m[ring_pos];
      ring_x_m[ring_pos] = cx;
      ring_y_m[ring_pos] = cy;
      ring_pos = (ring_pos + 1 >= FILTER_LEN) ? 0 : ring_pos + 1;
      sx = round_div(acc_x, FILTER_LEN);
      sy = round_div(acc_y, FILTER_LEN);
      disp_x_m = clamp(disp_x_m + round_div(sx, DISP_DIV), 48);
      disp_y_m = clamp(disp_y_m + round_div(sy, DISP_DIV), 48);
      if (conf < 0) conf = 0;
      if (conf > CONF_MAX) conf = CONF_MAX;
      v.sx = sx[39:0];
      v.sy = sy[39:0];
      v.psx = 40'(clamp(px, 40));
      v.psy = 40'(clamp(py, 40));
      v.ox = disp_x_m[47:0];
      v.oy = disp_y_m[47:0];
      v.conf = conf[16:0];
      velocity_queue.push_back(v);
   endtask

   task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
      $display("MISMATCH frame %0d %s: got %h expected %h", frames_seen, what, got, want);
      errors++;
   endtask

   // request driver
   always @(negedge clock) begin
      if (req_valid && !req_took) begin
         // hold the stalled request
      end else if (!reset && byte_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
         sensor_byte_t it;
         it = byte_queue.pop_front();
         req_valid <= 1'b1;
         req_rx_byte <= it.rx;
         req_height_mm <= it.h;
         req_gyro_roll_rate <= it.gr;
         req_gyro_pitch_rate <= it.gp;
      end else begin
         req_valid <= 1'b0;
      end
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   // monitor, prediction and watchdog
   always @(posedge clock) begin
      velocity_t v;
      req_took <= req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         sensor_byte_t it;
         it.rx = req_rx_byte;
         it.h = req_height_mm;
         it.gr = req_gyro_roll_rate;
         it.gp = req_gyro_pitch_rate;
         track_byte(it);
         bytes_sent++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (velocity_queue.size() == 0) begin
            report_mismatch("unexpected result", '0, '0);
         end else begin
            v = velocity_queue.pop_front();
            if (rsp_speed_x !== v.sx) report_mismatch("speed_x", 48'(rsp_speed_x), 48'(v.sx));
            if (rsp_speed_y !== v.sy) report_mismatch("speed_y", 48'(rsp_speed_y), 48'(v.sy));
            if (rsp_plain_speed_x !== v.psx)
               report_mismatch("plain_speed_x", 48'(rsp_plain_speed_x), 48'(v.psx));
            if (rsp_plain_speed_y !== v.psy)
               report_mismatch("plain_speed_y", 48'(rsp_plain_speed_y), 48'(v.psy));
            if (rsp_offset_x !== v.ox) report_mismatch("offset_x", rsp_offset_x, v.ox);
            if (rsp_offset_y !== v.oy) report_mismatch("offset_y", rsp_offset_y, v.oy);
            if (rsp_confidence_raw !== v.conf)
               report_mismatch("confidence_raw", 48'(rsp_confidence_raw), 48'(v.conf));
         end
         frames_seen++;
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else if (byte_queue.size() != 0 || velocity_queue.size() != 0 || req_valid)
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic signed [19:0] rand_rate();
      case ($urandom_range(3))
         0: return 20'sh80000;
         1: return 20'sh7FFFF;
         default: return 20'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(4))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2000)) - 1000);
         2: return 32'($signed($urandom_range(1 << 21)) - (1 << 20));
         3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($urandom_range(120000));
      endcase
   endfunction

   function automatic logic [15:0] rand_height();
      case ($urandom_range(5))
         0: return 16'hFFFF;
         1: return 16'h0000;
         2: return 16'($urandom_range(3000));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic put_byte(logic [7:0] rx, logic [15:0] h, logic signed [19:0] gr,
                           logic signed [19:0] gp);
      sensor_byte_t it;
      it.rx = rx;
      it.h = h;
      it.gr = gr;
      it.gp = gp;
      byte_queue.push_back(it);
   endtask

   task automatic put_noise(logic [7:0] rx);
      put_byte(rx, 16'($urandom), 20'($urandom), 20'($urandom));
   endtask

   task automatic put_frame(logic [31:0] a, logic [31:0] b, logic [31:0] conf,
                            logic [15:0] h, logic signed [19:0] gr,
                            logic signed [19:0] gp);
      logic [95:0] body;
      body = {conf, b, a};
      put_noise(HDR_FIRST);
      put_noise(HDR_SECOND);
      for (int i = 0; i < PAYLOAD_BYTES - 1; i++) put_noise(body[8*i +: 8]);
      put_byte(body[88 +: 8], h, gr, gp);
   endtask

   task automatic put_random(int n);
      int count;
      count = 0;
      while (count < n) begin
         if ($urandom_range(99) < 80) begin
            put_frame(rand_word(), rand_word(), rand_word(), rand_height(),
                      rand_rate(), rand_rate());
            count += 14;
         end else begin
            case ($urandom_range(2))
               0: put_noise(8'($urandom));
               1: begin
                  put_noise(HDR_FIRST);
                  put_noise(8'($urandom));
               end
               default: begin
                  // header then a truncated payload
                  put_noise(HDR_FIRST);
                  put_noise(HDR_SECOND);
                  repeat ($urandom_range(1, 5)) put_noise(8'($urandom));
               end
            endcase
            count += 2;
         end
      end
   endtask

   task automatic write_gain(logic idx, logic [GAIN_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_ROLL_GAIN) roll_gain_m = value;
      else pitch_gain_m = value;
   endtask

   task automatic drain();
      while (byte_queue.size() != 0 || velocity_queue.size() != 0 || req_valid)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      roll_gain_m = GAIN_RESET;
      pitch_gain_m = GAIN_RESET;
      hunt = 0;
      byte_no = 0;
      ring_pos = 0;
      acc_x = 0;
      acc_y = 0;
      disp_x_m = 0;
      disp_y_m = 0;
      for (int i = 0; i < FILTER_LEN; i++) begin
         ring_x_m[i] = 0;
         ring_y_m[i] = 0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: broken headers, field extremes, confidence clamping
      send_idle = 31;
      recv_idle = 63;
      put_noise(8'h00);
      put_noise(HDR_SECOND);
      put_noise(HDR_FIRST);
      put_noise(HDR_FIRST);
      put_noise(HDR_SECOND);
      put_noise(HDR_FIRST);
      put_noise(8'hAF);
      put_frame(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'hFFFF,
                20'sh7FFFF, 20'sh80000);
      put_frame(32'h8000_0000, 32'h7FFF_FFFF, 32'd100000, 16'h0000,
                20'sh80000, 20'sh7FFFF);
      put_frame(32'd1234, 32'hFFFF_F000, 32'd100001, 16'd1000, 20'sd0, 20'sd0);
      put_frame(32'h0000_00FF, 32'h00FF_0000, 32'h8000_0000, 16'hFFFF,
                20'sh7FFFF, 20'sh7FFFF);
      put_random(400);
      drain();

      send_idle = 63;
      recv_idle = 31;
      write_gain(CSR_ROLL_GAIN, '0);
      write_gain(CSR_PITCH_GAIN, '1);
      put_frame(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd5, 16'hFFFF, 20'sh80000, 20'sh80000);
      put_random(400);
      drain();

      send_idle = 0;
      recv_idle = 0;
      write_gain(CSR_ROLL_GAIN, '1);
      write_gain(CSR_PITCH_GAIN, GAIN_W'($urandom));
      put_random(200);
      drain();
      write_gain(CSR_ROLL_GAIN, GAIN_W'($urandom));
      write_gain(CSR_PITCH_GAIN, '0);
      put_random(200);
      drain();

      $display("Run: %0d sensor bytes accepted, %0d frames checked, four gain settings",
               bytes_sent, frames_seen);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", errors);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/ofv_pkg.sv
rtl/core/ofv_div.sv
rtl/core/ofv_dp.sv
rtl/core/ofv_ctrl.sv
rtl/core/optical_flow_frame_velocity_core.sv
tb/sv/tb.sv
